// File: sv/wake_sleep_planner_assert.svh
// Assertion macros shared by the wake/sleep planner RTL.
// Expects clk and rst_n in the scope where the macros are used.
`ifndef WAKE_SLEEP_PLANNER_ASSERT_SVH
`define WAKE_SLEEP_PLANNER_ASSERT_SVH

// Same-cycle implication, disabled during reset
`define WSP_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled during reset
`define WSP_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: sv/wsp_pkg.sv
// Package for the wake/sleep planner: field widths, code constants, helpers.
// No dependencies; imported by the channel interfaces and the top level.
`default_nettype none

package wsp_pkg;

  // Field widths
  localparam int unsigned IVAL_W   = 32;
  localparam int unsigned TIME_W   = 64;
  localparam int unsigned FAIL_W   = 16;
  localparam int unsigned CODE_W   = 2;
  localparam int unsigned SLEEP_W  = 32;
  localparam int unsigned BASE_W   = 20;  // any clamped base fits here
  localparam int unsigned MIN_W    = 12;
  localparam int unsigned MAX_W    = 20;
  localparam int unsigned FB_W     = 17;
  localparam int unsigned EPOCH_W  = 32;
  localparam int unsigned CFG_IDX_W = 3;
  localparam int unsigned CFG_DAT_W = 32;

  // Interval source codes
  localparam logic [CODE_W-1:0] SRC_POLICY = 2'd0;
  localparam logic [CODE_W-1:0] SRC_LOCAL  = 2'd1;
  localparam logic [CODE_W-1:0] SRC_CHANGE = 2'd2;

  // Action codes
  localparam logic [CODE_W-1:0] ACT_STAY    = 2'd0;
  localparam logic [CODE_W-1:0] ACT_REFRESH = 2'd1;
  localparam logic [CODE_W-1:0] ACT_SLEEP   = 2'd2;

  // Wake causes
  localparam logic [CODE_W-1:0] WAKE_BUTTON = 2'd1;
  localparam logic [CODE_W-1:0] WAKE_COLD   = 2'd2;

  // Fetch outcomes
  localparam logic [CODE_W-1:0] FETCH_CHANGED   = 2'd0;
  localparam logic [CODE_W-1:0] FETCH_UNCHANGED = 2'd1;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_POLL_MIN    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_POLL_MAX    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_BACKOFF_CAP = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_FALLBACK    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_SYNCED      = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_SLEEP_EN    = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_URL         = 3'd6;

  // Register reset values
  localparam logic [MIN_W-1:0]   RST_POLL_MIN    = 12'd30;
  localparam logic [MAX_W-1:0]   RST_POLL_MAX    = 20'd86400;
  localparam logic [MAX_W-1:0]   RST_BACKOFF_CAP = 20'd3600;
  localparam logic [FB_W-1:0]    RST_FALLBACK    = 17'd900;
  localparam logic [EPOCH_W-1:0] RST_SYNCED      = 32'd1700000000;

  // Backoff constants
  localparam logic [FAIL_W-1:0] FAIL_JUMP     = 16'd10;
  localparam logic [FAIL_W-1:0] FAIL_MULT_MIN = 16'd4;
  localparam logic [2:0]        BACKOFF_MULT  = 3'd5;
  localparam logic [FAIL_W-1:0] FAIL_SAT      = '1;

  // Floor test first, then ceiling; result never exceeds 20 bits
  function automatic logic [BASE_W-1:0] clamp_ival(
    input logic [IVAL_W-1:0] s,
    input logic [MIN_W-1:0]  mn,
    input logic [MAX_W-1:0]  mx
  );
    logic [BASE_W-1:0] r;
    if (s < IVAL_W'(mn)) begin
      r = BASE_W'(mn);
    end else if (s > IVAL_W'(mx)) begin
      r = mx;
    end else begin
      r = s[BASE_W-1:0];
    end
    return r;
  endfunction

endpackage

`default_nettype wire

// File: sv/wsp_in_if.sv
// Wake report channel: valid/ready handshake plus the report fields.
// Depends on wsp_pkg for field widths.
`default_nettype none

interface wsp_in_if;
  import wsp_pkg::*;

  logic                valid;
  logic                ready;
  logic [IVAL_W-1:0]   policy_interval;
  logic [IVAL_W-1:0]   local_interval;
  logic signed [TIME_W-1:0] change_time;
  logic signed [TIME_W-1:0] now_time;
  logic [FAIL_W-1:0]   fail_count;
  logic [CODE_W-1:0]   wake_cause;
  logic                rtc_sig_ok;
  logic [CODE_W-1:0]   fetch_outcome;
  logic                batt_fitted;
  logic                usb_attached;

  modport source (
    output valid, policy_interval, local_interval, change_time, now_time,
           fail_count, wake_cause, rtc_sig_ok, fetch_outcome, batt_fitted,
           usb_attached,
    input  ready
  );

  modport sink (
    input  valid, policy_interval, local_interval, change_time, now_time,
           fail_count, wake_cause, rtc_sig_ok, fetch_outcome, batt_fitted,
           usb_attached,
    output ready
  );

endinterface

`default_nettype wire

// File: sv/wsp_out_if.sv
// Sleep plan channel: valid/ready handshake plus the plan fields.
// Depends on wsp_pkg for field widths.
`default_nettype none

interface wsp_out_if;
  import wsp_pkg::*;

  logic               valid;
  logic               ready;
  logic [SLEEP_W-1:0] sleep_secs;
  logic [CODE_W-1:0]  interval_source;
  logic [CODE_W-1:0]  action;
  logic [FAIL_W-1:0]  next_fail_count;

  modport source (
    output valid, sleep_secs, interval_source, action, next_fail_count,
    input  ready
  );

  modport sink (
    input  valid, sleep_secs, interval_source, action, next_fail_count,
    output ready
  );

endinterface

`default_nettype wire

// File: sv/wake_sleep_planner.sv
// Pipeline: three register stages (stage 1, stage 2 and the output registers) lie
// between an input transfer and the plan that it produces on out_ch.
// Throughput: one report per cycle while out_ch does not stall; the three stages
// (clamp and time difference, change-instant shortening, backoff and cap) advance together.
// A stall on out_ch holds every stage in place and drops in_ch.ready.
// Reset (rst_n low, synchronous) empties the pipeline and reloads the registers.
`default_nettype none

module wake_sleep_planner (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  wsp_in_if.sink                             in_ch,
  wsp_out_if.source                          out_ch,
  input  wire logic                          cfg_we,
  input  wire logic [wsp_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [wsp_pkg::CFG_DAT_W-1:0] cfg_wdata
);
  import wsp_pkg::*;

  // Configuration registers
  logic [MIN_W-1:0]   poll_min_r;
  logic [MAX_W-1:0]   poll_max_r;
  logic [MAX_W-1:0]   cap_r;
  logic [FB_W-1:0]    fallback_r;
  logic [EPOCH_W-1:0] synced_r;
  logic               sleep_en_r;
  logic               url_r;

  // Stage 1 registers
  logic               s1_valid_r;
  logic [BASE_W-1:0]  s1_base_r;
  logic [CODE_W-1:0]  s1_src_r;
  logic               s1_sync_r;
  logic [TIME_W-1:0]  s1_diff_r;
  logic [FAIL_W-1:0]  s1_fails_r;
  logic [CODE_W-1:0]  s1_action_r;
  logic [FAIL_W-1:0]  s1_next_r;

  // Stage 2 registers
  logic               s2_valid_r;
  logic [BASE_W-1:0]  s2_base_r;
  logic [CODE_W-1:0]  s2_src_r;
  logic [FAIL_W-1:0]  s2_fails_r;
  logic [CODE_W-1:0]  s2_action_r;
  logic [FAIL_W-1:0]  s2_next_r;

  // Output registers
  logic               out_valid_r;
  logic [BASE_W-1:0]  out_sleep_r;
  logic [CODE_W-1:0]  out_src_r;
  logic [CODE_W-1:0]  out_action_r;
  logic [FAIL_W-1:0]  out_next_r;

  // Next values
  logic [BASE_W-1:0]  s1_base_nxt;
  logic [CODE_W-1:0]  s1_src_nxt;
  logic               s1_sync_nxt;
  logic [TIME_W-1:0]  s1_diff_nxt;
  logic [CODE_W-1:0]  s1_action_nxt;
  logic [FAIL_W-1:0]  s1_next_nxt;
  logic [BASE_W-1:0]  s2_base_nxt;
  logic [CODE_W-1:0]  s2_src_nxt;
  logic [BASE_W-1:0]  out_sleep_nxt;

  logic               adv;
  logic               in_xfer;
  logic               diff_pos;
  logic               diff_small;
  logic [BASE_W+2:0]  base_x5;
  logic [BASE_W+2:0]  backoff;
  logic [BASE_W+2:0]  capped;

  // Assertion helpers
  logic               sleep_hi_zero;
  logic               s2_is_chg;
  logic               stay_adv;

  // Whole pipeline moves when the output slot is free or being taken
  assign adv          = out_ch.ready || !out_valid_r;
  assign in_ch.ready  = adv;
  assign in_xfer      = in_ch.valid && adv;

  // Configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      poll_min_r <= RST_POLL_MIN;
      poll_max_r <= RST_POLL_MAX;
      cap_r      <= RST_BACKOFF_CAP;
      fallback_r <= RST_FALLBACK;
      synced_r   <= RST_SYNCED;
      sleep_en_r <= 1'b1;
      url_r      <= 1'b1;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_POLL_MIN:    poll_min_r <= cfg_wdata[MIN_W-1:0];
        CFG_POLL_MAX:    poll_max_r <= cfg_wdata[MAX_W-1:0];
        CFG_BACKOFF_CAP: cap_r      <= cfg_wdata[MAX_W-1:0];
        CFG_FALLBACK:    fallback_r <= cfg_wdata[FB_W-1:0];
        CFG_SYNCED:      synced_r   <= cfg_wdata[EPOCH_W-1:0];
        CFG_SLEEP_EN:    sleep_en_r <= cfg_wdata[0];
        CFG_URL:         url_r      <= cfg_wdata[0];
        default: ;
      endcase
    end
  end

  // Stage 1: base selection, sync test, time difference, action decision
  always_comb begin
    if (in_ch.policy_interval != '0) begin
      s1_base_nxt = clamp_ival(in_ch.policy_interval, poll_min_r, poll_max_r);
      s1_src_nxt  = SRC_POLICY;
    end else begin
      s1_src_nxt = SRC_LOCAL;
      if (in_ch.local_interval != '0) begin
        s1_base_nxt = clamp_ival(in_ch.local_interval, poll_min_r, poll_max_r);
      end else begin
        s1_base_nxt = BASE_W'(fallback_r);
      end
    end

    // change must be positive; now must be nonnegative and at or past the sync epoch
    s1_sync_nxt = (in_ch.change_time > 0) && !in_ch.now_time[TIME_W-1] &&
                  (in_ch.now_time >= $signed({{(TIME_W-EPOCH_W){1'b0}}, synced_r}));
    s1_diff_nxt = in_ch.change_time - in_ch.now_time;

    // Safety gates first, then wake cause, RTC and fetch outcome
    s1_action_nxt = ACT_STAY;
    s1_next_nxt   = in_ch.fail_count;
    if (sleep_en_r && in_ch.batt_fitted && !in_ch.usb_attached && url_r &&
        (in_ch.wake_cause != WAKE_BUTTON)) begin
      if ((in_ch.wake_cause == WAKE_COLD) || !in_ch.rtc_sig_ok) begin
        s1_action_nxt = ACT_REFRESH;
        s1_next_nxt   = '0;
      end else begin
        case (in_ch.fetch_outcome)
          FETCH_CHANGED: begin
            s1_action_nxt = ACT_REFRESH;
          end
          FETCH_UNCHANGED: begin
            s1_action_nxt = ACT_SLEEP;
            s1_next_nxt   = '0;
          end
          default: begin
            s1_action_nxt = ACT_SLEEP;
            if (in_ch.fail_count != FAIL_SAT) begin
              s1_next_nxt = in_ch.fail_count + 1'b1;
            end
          end
        endcase
      end
    end
  end

  // Stage 2: shorten to a strictly future change instant, floored at poll_min
  always_comb begin
    diff_pos    = !s1_diff_r[TIME_W-1] && (s1_diff_r != '0);
    diff_small  = (s1_diff_r[TIME_W-1:BASE_W] == '0) &&
                  (s1_diff_r[BASE_W-1:0] < s1_base_r);
    s2_base_nxt = s1_base_r;
    s2_src_nxt  = s1_src_r;
    if (s1_sync_r && diff_pos && diff_small) begin
      s2_src_nxt  = SRC_CHANGE;
      s2_base_nxt = (s1_diff_r[BASE_W-1:0] > BASE_W'(poll_min_r)) ?
                    s1_diff_r[BASE_W-1:0] : BASE_W'(poll_min_r);
    end
  end

  // Stage 3: backoff, cap, then floor at the base
  always_comb begin
    base_x5 = (BASE_W+3)'(s2_base_r) * (BASE_W+3)'(BACKOFF_MULT);
    if (s2_fails_r > FAIL_JUMP) begin
      backoff = (BASE_W+3)'(cap_r);
    end else if (s2_fails_r >= FAIL_MULT_MIN) begin
      backoff = base_x5;
    end else begin
      backoff = (BASE_W+3)'(s2_base_r);
    end
    capped = (backoff > (BASE_W+3)'(cap_r)) ? (BASE_W+3)'(cap_r) : backoff;
    out_sleep_nxt = (capped < (BASE_W+3)'(s2_base_r)) ? s2_base_r :
                    capped[BASE_W-1:0];
  end

  // Valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      s2_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else if (adv) begin
      s1_valid_r  <= in_xfer;
      s2_valid_r  <= s1_valid_r;
      out_valid_r <= s2_valid_r;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (adv) begin
      s1_base_r    <= s1_base_nxt;
      s1_src_r     <= s1_src_nxt;
      s1_sync_r    <= s1_sync_nxt;
      s1_diff_r    <= s1_diff_nxt;
      s1_fails_r   <= in_ch.fail_count;
      s1_action_r  <= s1_action_nxt;
      s1_next_r    <= s1_next_nxt;

      s2_base_r    <= s2_base_nxt;
      s2_src_r     <= s2_src_nxt;
      s2_fails_r   <= s1_fails_r;
      s2_action_r  <= s1_action_r;
      s2_next_r    <= s1_next_r;

      out_sleep_r  <= out_sleep_nxt;
      out_src_r    <= s2_src_r;
      out_action_r <= s2_action_r;
      out_next_r   <= s2_next_r;
    end
  end

  // Output channel
  assign out_ch.valid           = out_valid_r;
  assign out_ch.sleep_secs      = SLEEP_W'(out_sleep_r);
  assign out_ch.interval_source = out_src_r;
  assign out_ch.action          = out_action_r;
  assign out_ch.next_fail_count = out_next_r;

  // Conditions the checks below refer to
  assign sleep_hi_zero = (out_ch.sleep_secs[SLEEP_W-1:BASE_W] == '0);
  assign s2_is_chg     = s2_valid_r && (s2_src_r == SRC_CHANGE);
  assign stay_adv      = adv && s2_valid_r && (s2_action_r == ACT_STAY);

  `include "wake_sleep_planner_assert.svh"

  // Sleep never exceeds the 20-bit range of a clamped base
  `WSP_ASSERT_NOW(a_sleep_range, out_valid_r, sleep_hi_zero, "sleep out of range")
  // A stall freezes the stage 1 slot
  `WSP_ASSERT_NEXT(a_stall_hold, !adv, $stable(s1_valid_r) && $stable(s1_base_r), "s1 moved")
  // A change-instant base is floored at poll_min
  `WSP_ASSERT_NOW(a_change_floor, s2_is_chg, s2_base_r >= BASE_W'(poll_min_r), "base < poll_min")
  // Stay-awake plans carry the count through unchanged from stage 2
  `WSP_ASSERT_NEXT(a_stay_count, stay_adv, out_next_r == $past(s2_fails_r), "stay count moved")

endmodule

`default_nettype wire
